/* design/stc_pkg.sv */
// Shared widths and tdata layout for the segment/triangle intersection block.
// Depends on nothing; used by the top level and the divider.
`default_nettype none

package stc_pkg;

   // field widths as they travel on the stream
   localparam int POINT_W  = 60;
   localparam int NORMAL_W = 48;
   localparam int HIT_W    = 20;

   // request tdata offsets, lowest field first
   localparam int REQ_VA_LSB  = 0;
   localparam int REQ_VB_LSB  = REQ_VA_LSB + POINT_W;
   localparam int REQ_VC_LSB  = REQ_VB_LSB + POINT_W;
   localparam int REQ_SS_LSB  = REQ_VC_LSB + POINT_W;
   localparam int REQ_SE_LSB  = REQ_SS_LSB + POINT_W;
   localparam int REQ_NRM_LSB = REQ_SE_LSB + POINT_W;
   localparam int REQ_BITS    = REQ_NRM_LSB + NORMAL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response tdata: crossed, inside, hit x, y, z
   localparam int RSP_BITS    = 2 + 3 * HIT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // quotient bits retired by each divider stage
   localparam int DIV_BITS_PER_STAGE = 1;

endpackage

`default_nettype wire

/* design/stc_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on stc_pkg for the stage step size.
`default_nettype none

module stc_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 40,
   parameter int QUO_W = 20
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);

   localparam int STEP = stc_pkg::DIV_BITS_PER_STAGE;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   genvar j;
   generate
      for (j = 0; j < QUO_W; j++) begin : g_stage
         localparam int SH = QUO_W - STEP - j;
         logic [NUM_W-1:0] rem_prev;
         logic [QUO_W-1:0] quo_prev;
         logic [DEN_W-1:0] den_prev;
         logic [NUM_W-1:0] trial;
         logic [NUM_W-1:0] rem_in;
         logic [QUO_W-1:0] quo_in;

         if (j == 0) begin : g_first
            assign rem_prev = num;
            assign quo_prev = '0;
            assign den_prev = den;
         end else begin : g_next
            assign rem_prev = rem_ff[j-1];
            assign quo_prev = quo_ff[j-1];
            assign den_prev = den_ff[j-1];
         end

         // subtract the shifted divisor when it fits
         always_comb begin
            trial  = NUM_W'(den_prev) << SH;
            rem_in = rem_prev;
            quo_in = quo_prev;
            if (rem_prev >= trial) begin
               rem_in     = rem_prev - trial;
               quo_in[SH] = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               quo_ff[j] <= quo_in;
               den_ff[j] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

/* design/segment_triangle_intersection.sv */
// Segment against triangle test: plane crossing, hit point, inside flag.
// Depends on stc_pkg and stc_divider (three instances, one per axis).
//
//   channel  dir  tdata fields (low bit first)
//   req_     in   vertex_a, vertex_b, vertex_c, segment_start, segment_end,
//                 plane_normal
//   rsp_     out  plane_crossed, inside_triangle, hit_x, hit_y, hit_z
//
// One word in per clock while the skid is empty. The pipeline has seven front
// stages (centroid, dots, weights), COORD_BITS divider stages, four back
// stages (hit point, edge tests), and the output register.
// Reset clears the valid bits and the output skid; payload is not reset.
// The pipeline moves on a single enable; a result the sink refuses parks in
// a skid register, and the enable drops only while that register is full.
`default_nettype none

module segment_triangle_intersection #(
   parameter int COORD_BITS  = 20,
   parameter int NORMAL_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // vertex_a, vertex_b, vertex_c, segment_start, segment_end, plane_normal
   input  wire logic [stc_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // plane_crossed, inside_triangle, hit_x, hit_y, hit_z
   output logic [stc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int C    = COORD_BITS;
   localparam int N    = NORMAL_BITS;
   localparam int VW   = (3 * C > stc_pkg::POINT_W) ? 3 * C : stc_pkg::POINT_W;
   localparam int SW   = C + 2;
   localparam int AW   = C + 1;
   localparam int RS   = AW + 2;
   localparam int MW   = AW + RS;
   localparam logic [RS-1:0] RECIP = RS'((longint'(1) << RS) / 3);
   localparam int DW   = C + 1;
   localparam int PW   = N + DW;
   localparam int DOTW = PW + 2;
   localparam int DENW = DOTW + 1;
   localparam int WPW  = C + DENW;
   localparam int NUMW = WPW + 1;
   localparam int XW   = 2 * DW;
   localparam int CW   = XW + 1;
   localparam int NCW  = N + CW;
   localparam int EW   = NCW + 2;
   localparam int NVLD = 11 + C;

   typedef struct packed {
      logic [2:0][2:0][C-1:0] v;
      logic [2:0][C-1:0]      s;
      logic [2:0][C-1:0]      e;
      logic [2:0][N-1:0]      nrm;
   } carry_type;

   typedef struct packed {
      carry_type  c;
      logic       crossed;
      logic       den_zero;
      logic [2:0] neg;
   } meta_type;

   typedef struct packed {
      logic                 crossed;
      logic                 inside_tri;
      logic [2:0][C-1:0]    hit;
   } result_type;

   // ---------------- stall control ----------------
   logic            en;
   logic [NVLD-1:0] vld_ff;
   logic            last_vld;
   logic            out_vld_ff, skid_vld_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign last_vld   = vld_ff[NVLD-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NVLD-2:0], req_tvalid};
      end
   end

   // ---------------- stage 1: unpack, vertex sums ----------------
   logic [VW-1:0]           wa, wb, wc, ws, we;
   carry_type               c0;
   logic signed [SW-1:0]    sum_in [3];
   carry_type               c1_ff;
   logic signed [SW-1:0]    sum_ff [3];

   assign wa = VW'(req_tdata[stc_pkg::REQ_VA_LSB +: stc_pkg::POINT_W]);
   assign wb = VW'(req_tdata[stc_pkg::REQ_VB_LSB +: stc_pkg::POINT_W]);
   assign wc = VW'(req_tdata[stc_pkg::REQ_VC_LSB +: stc_pkg::POINT_W]);
   assign ws = VW'(req_tdata[stc_pkg::REQ_SS_LSB +: stc_pkg::POINT_W]);
   assign we = VW'(req_tdata[stc_pkg::REQ_SE_LSB +: stc_pkg::POINT_W]);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c0.v[0][k] = wa[k*C +: C];
         c0.v[1][k] = wb[k*C +: C];
         c0.v[2][k] = wc[k*C +: C];
         c0.s[k]    = ws[k*C +: C];
         c0.e[k]    = we[k*C +: C];
         c0.nrm[k]  = req_tdata[stc_pkg::REQ_NRM_LSB + k*N +: N];
         sum_in[k]  = SW'(signed'(c0.v[0][k])) + SW'(signed'(c0.v[1][k]))
                    + SW'(signed'(c0.v[2][k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c0;
         for (int k = 0; k < 3; k++) sum_ff[k] <= sum_in[k];
      end
   end

   // ---------------- stage 2: |sum| times reciprocal of three ----------------
   logic [AW-1:0] mag_in [3];
   logic [AW-1:0] mag_ff [3];
   logic [MW-1:0] rp_ff  [3];
   logic [2:0]    sneg_ff;
   carry_type     c2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = sum_ff[k][SW-1] ? AW'(-sum_ff[k]) : AW'(sum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff <= c1_ff;
         for (int k = 0; k < 3; k++) begin
            mag_ff[k]  <= mag_in[k];
            rp_ff[k]   <= MW'(mag_in[k]) * MW'(RECIP);
            sneg_ff[k] <= sum_ff[k][SW-1];
         end
      end
   end

   // ---------------- stage 3: centroid fix-up, offsets ----------------
   logic [AW-1:0]        q0 [3];
   logic [AW-1:0]        q1 [3];
   logic [AW-1:0]        rr [3];
   logic signed [DW-1:0] cen [3];
   logic signed [DW-1:0] ds_ff [3];
   logic signed [DW-1:0] de_ff [3];
   carry_type            c3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q0[k]  = rp_ff[k][MW-1:RS];
         rr[k]  = mag_ff[k] - (q0[k] + (q0[k] << 1));
         q1[k]  = (rr[k] >= AW'(3)) ? q0[k] + AW'(1) : q0[k];
         cen[k] = sneg_ff[k] ? -signed'(DW'(q1[k])) : signed'(DW'(q1[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff <= c2_ff;
         for (int k = 0; k < 3; k++) begin
            ds_ff[k] <= DW'(signed'(c2_ff.s[k])) - cen[k];
            de_ff[k] <= DW'(signed'(c2_ff.e[k])) - cen[k];
         end
      end
   end

   // ---------------- stage 4: normal products ----------------
   logic signed [PW-1:0] pds_ff [3];
   logic signed [PW-1:0] pde_ff [3];
   carry_type            c4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff <= c3_ff;
         for (int k = 0; k < 3; k++) begin
            pds_ff[k] <= PW'(signed'(c3_ff.nrm[k])) * PW'(ds_ff[k]);
            pde_ff[k] <= PW'(signed'(c3_ff.nrm[k])) * PW'(de_ff[k]);
         end
      end
   end

   // ---------------- stage 5: plane distances, crossing ----------------
   logic signed [DOTW-1:0] dsum, dend;
   logic                   cross_in;
   logic [DOTW-1:0]        m_ff, n_ff;
   logic                   cross5_ff;
   carry_type              c5_ff;

   always_comb begin
      dsum = DOTW'(pds_ff[0]) + DOTW'(pds_ff[1]) + DOTW'(pds_ff[2]);
      dend = DOTW'(pde_ff[0]) + DOTW'(pde_ff[1]) + DOTW'(pde_ff[2]);
      cross_in = (dsum == '0) || (dend == '0) || (dsum[DOTW-1] != dend[DOTW-1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff     <= c4_ff;
         cross5_ff <= cross_in;
         m_ff      <= dsum[DOTW-1] ? DOTW'(-dsum) : DOTW'(dsum);
         n_ff      <= dend[DOTW-1] ? DOTW'(-dend) : DOTW'(dend);
      end
   end

   // ---------------- stage 6: weighted endpoints ----------------
   logic signed [WPW-1:0] sn_ff [3];
   logic signed [WPW-1:0] em_ff [3];
   logic [DENW-1:0]       den6_ff;
   logic                  cross6_ff;
   carry_type             c6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c6_ff     <= c5_ff;
         cross6_ff <= cross5_ff;
         den6_ff   <= DENW'(m_ff) + DENW'(n_ff);
         for (int k = 0; k < 3; k++) begin
            sn_ff[k] <= WPW'(signed'(c5_ff.s[k])) * signed'(WPW'(n_ff));
            em_ff[k] <= WPW'(signed'(c5_ff.e[k])) * signed'(WPW'(m_ff));
         end
      end
   end

   // ---------------- stage 7: numerator magnitude ----------------
   logic signed [NUMW-1:0] num_s [3];
   logic [NUMW-1:0]        dnum_ff [3];
   logic [DENW-1:0]        dden_ff;
   meta_type               m7_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_s[k] = NUMW'(sn_ff[k]) + NUMW'(em_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dden_ff          <= den6_ff;
         m7_ff.c          <= c6_ff;
         m7_ff.crossed    <= cross6_ff;
         m7_ff.den_zero   <= (den6_ff == '0);
         for (int k = 0; k < 3; k++) begin
            dnum_ff[k]    <= num_s[k][NUMW-1] ? NUMW'(-num_s[k]) : NUMW'(num_s[k]);
            m7_ff.neg[k]  <= num_s[k][NUMW-1];
         end
      end
   end

   // ---------------- divider stages ----------------
   logic [C-1:0] quo [3];
   meta_type     md_ff [C];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_div
         stc_divider #(
            .NUM_W (NUMW),
            .DEN_W (DENW),
            .QUO_W (C)
         ) u_div (
            .clock (clock),
            .en    (en),
            .num   (dnum_ff[g]),
            .den   (dden_ff),
            .quo   (quo[g])
         );
      end
      for (g = 0; g < C; g++) begin : g_meta
         always_ff @(posedge clock) begin
            if (en) begin
               md_ff[g] <= (g == 0) ? m7_ff : md_ff[(g == 0) ? 0 : g - 1];
            end
         end
      end
   endgenerate

   // ---------------- stage 8: hit point ----------------
   meta_type            mh;
   logic [C-1:0]        hit_in [3];
   logic signed [C-1:0] hit_ff [3];
   logic                cross8_ff;
   carry_type           c8_ff;

   assign mh = md_ff[C-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!mh.crossed) begin
            hit_in[k] = '0;
         end else if (mh.den_zero) begin
            hit_in[k] = mh.c.s[k];
         end else if (mh.neg[k]) begin
            hit_in[k] = -quo[k];
         end else begin
            hit_in[k] = quo[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c8_ff     <= mh.c;
         cross8_ff <= mh.crossed;
         for (int k = 0; k < 3; k++) hit_ff[k] <= signed'(hit_in[k]);
      end
   end

   // ---------------- stage 9: edge vectors and cross terms ----------------
   logic signed [DW-1:0] hv [3][3];
   logic signed [DW-1:0] ed [3][3];
   logic signed [XW-1:0] xa_ff [3][3];
   logic signed [XW-1:0] xb_ff [3][3];
   logic signed [C-1:0]  hit9_ff [3];
   logic                 cross9_ff;
   logic [2:0][N-1:0]    nrm9_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            hv[i][k] = DW'(hit_ff[k]) - DW'(signed'(c8_ff.v[i][k]));
            ed[i][k] = DW'(signed'(c8_ff.v[(i + 2) % 3][k]))
                     - DW'(signed'(c8_ff.v[i][k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cross9_ff <= cross8_ff;
         nrm9_ff   <= c8_ff.nrm;
         for (int k = 0; k < 3; k++) hit9_ff[k] <= hit_ff[k];
         for (int i = 0; i < 3; i++) begin
            xa_ff[i][0] <= XW'(hv[i][1]) * XW'(ed[i][2]);
            xb_ff[i][0] <= XW'(hv[i][2]) * XW'(ed[i][1]);
            xa_ff[i][1] <= XW'(hv[i][2]) * XW'(ed[i][0]);
            xb_ff[i][1] <= XW'(hv[i][0]) * XW'(ed[i][2]);
            xa_ff[i][2] <= XW'(hv[i][0]) * XW'(ed[i][1]);
            xb_ff[i][2] <= XW'(hv[i][1]) * XW'(ed[i][0]);
         end
      end
   end

   // ---------------- stage 10: cross products ----------------
   logic signed [CW-1:0] cp_ff [3][3];
   logic signed [C-1:0]  hit10_ff [3];
   logic                 cross10_ff;
   logic [2:0][N-1:0]    nrm10_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cross10_ff <= cross9_ff;
         nrm10_ff   <= nrm9_ff;
         for (int k = 0; k < 3; k++) hit10_ff[k] <= hit9_ff[k];
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               cp_ff[i][k] <= CW'(xa_ff[i][k]) - CW'(xb_ff[i][k]);
            end
         end
      end
   end

   // ---------------- stage 11: normal dot cross ----------------
   logic signed [NCW-1:0] nc_ff [3][3];
   logic signed [C-1:0]   hit11_ff [3];
   logic                  cross11_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cross11_ff <= cross10_ff;
         for (int k = 0; k < 3; k++) hit11_ff[k] <= hit10_ff[k];
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               nc_ff[i][k] <= NCW'(signed'(nrm10_ff[k])) * NCW'(cp_ff[i][k]);
            end
         end
      end
   end

   // ---------------- edge signs, result word ----------------
   logic signed [EW-1:0] esum [3];
   result_type           res;

   always_comb begin
      res.crossed    = cross11_ff;
      res.inside_tri = cross11_ff;
      for (int i = 0; i < 3; i++) begin
         esum[i] = EW'(nc_ff[i][0]) + EW'(nc_ff[i][1]) + EW'(nc_ff[i][2]);
         if (esum[i][EW-1]) res.inside_tri = 1'b0;
      end
      for (int k = 0; k < 3; k++) res.hit[k] = hit11_ff[k];
   end

   // ---------------- output register with skid ----------------
   result_type out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= last_vld;
         end
      end else if (en && last_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_ff <= skid_vld_ff ? skid_ff : res;
      end else if (en && last_vld) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;

   always_comb begin
      rsp_tdata      = '0;
      rsp_tdata[0]   = out_ff.crossed;
      rsp_tdata[1]   = out_ff.inside_tri;
      for (int k = 0; k < 3; k++) begin
         rsp_tdata[2 + k*stc_pkg::HIT_W +: stc_pkg::HIT_W] =
            stc_pkg::HIT_W'(out_ff.hit[k]);
      end
   end

endmodule

`default_nettype wire
